### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, all sampled on the rising edge of clock
// and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every sampled edge.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/lpdc_pkg.sv
// ----------------------------------------------------------------------------
// lpdc_pkg
// Types and constants shared by the LED pattern dimmer controller modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpdc_pkg;

   // Highest number of patterns the block is built for, and the limit set by
   // the four-bit pattern index.
   localparam int MAX_PATTERNS = 16;
   localparam int INDEX_LIMIT  = 16;
   localparam int EFF_LIMIT    = (MAX_PATTERNS > INDEX_LIMIT) ? INDEX_LIMIT :
                                 ((MAX_PATTERNS < 1) ? 1 : MAX_PATTERNS);

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam int DIV_STEPS   = 16;
   localparam int STEP_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS_MAX = 2'd1;

   localparam logic [4:0] PATTERN_COUNT_RESET  = 5'd1;
   localparam logic [7:0] BRIGHTNESS_MAX_RESET = 8'd255;

   typedef enum logic [2:0] {
      CMD_TOGGLE   = 3'd0,
      CMD_NEXT     = 3'd1,
      CMD_PREVIOUS = 3'd2,
      CMD_SELECT   = 3'd3,
      CMD_DIM      = 3'd4,
      CMD_BRIGHTEN = 3'd5
   } cmd_type;

   typedef struct packed {
      logic load_input;
      logic mult;
      logic div_step;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_pixel;
      logic running;
   } dp_status_type;

   typedef struct packed {
      logic       status;
      logic       start_pulse;
      logic       stop_pulse;
      logic [3:0] pattern_index;
      logic       is_on;
      logic [7:0] level;
      logic       pixel_drawn;
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       frame_end_out;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/lpdc_ctrl.sv
// ----------------------------------------------------------------------------
// lpdc_ctrl
// Sequencer: accepts one beat, steps the multiply and divide, loads the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lpdc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic                   rsp_ready,
   output      logic                   rsp_valid,
   input  wire lpdc_pkg::dp_status_type dp_status,
   output      lpdc_pkg::ctrl_cmd_type ctrl_cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   localparam logic [lpdc_pkg::STEP_CNT_W-1:0] LAST_STEP =
      lpdc_pkg::STEP_CNT_W'(lpdc_pkg::DIV_STEPS - 1);

   state_type                        state_ff;
   logic [lpdc_pkg::STEP_CNT_W-1:0]  step_cnt_ff;
   logic                             out_valid_ff;
   logic                             req_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      ctrl_cmd.load_input = req_fire;
      ctrl_cmd.mult       = (state_ff == ST_MULT);
      ctrl_cmd.div_step   = (state_ff == ST_DIVIDE);
      ctrl_cmd.out_load   = (state_ff == ST_FINISH) && (!out_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_cnt_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ctrl_cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_MULT;
               end
            end
            ST_MULT: begin
               step_cnt_ff <= '0;
               if (dp_status.is_pixel && dp_status.running) begin
                  state_ff <= ST_DIVIDE;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_DIVIDE: begin
               step_cnt_ff <= step_cnt_ff + 1'b1;
               if (step_cnt_ff == LAST_STEP) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (ctrl_cmd.out_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `ASSERT_IMPLIES(a_no_overwrite, out_valid_ff && !rsp_ready, !ctrl_cmd.out_load,
      "result register loaded while a stalled beat is still held")
   `ASSERT_NEXT(a_accept_to_mult, req_fire, state_ff == ST_MULT,
      "accepted beat did not move the sequencer to the multiply step")
   `ASSERT_NEXT(a_divide_count, state_ff == ST_DIVIDE && step_cnt_ff != LAST_STEP,
      state_ff == ST_DIVIDE && step_cnt_ff == $past(step_cnt_ff) + 1'b1,
      "divide step counter skipped or left the divide state early")

endmodule

`default_nettype wire

### rtl/lpdc_datapath.sv
// ----------------------------------------------------------------------------
// lpdc_datapath
// Controller state, configuration registers, per-channel multiply and
// restoring divider, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpdc_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic [lpdc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [lpdc_pkg::CSR_DATA_W-1:0]     csr_data,
   input  wire logic                                in_req_type,
   input  wire logic [2:0]                          in_command,
   input  wire logic [7:0]                          in_param,
   input  wire logic [7:0]                          in_red,
   input  wire logic [7:0]                          in_green,
   input  wire logic [7:0]                          in_blue,
   input  wire logic                                in_frame_end,
   input  wire lpdc_pkg::ctrl_cmd_type              ctrl_cmd,
   output      lpdc_pkg::dp_status_type             dp_status,
   output      lpdc_pkg::rsp_type                   rsp_out
);

   localparam logic [4:0] LIMIT = 5'(lpdc_pkg::EFF_LIMIT);

   // Configuration and controller state.
   logic [4:0] pattern_count_ff;
   logic [7:0] brightness_max_ff;
   logic       running_ff,  running_in;
   logic [7:0] level_ff,    level_in;
   logic [3:0] sel_ff,      sel_in;

   // Latched input beat.
   logic       is_pixel_ff;
   logic [2:0] cmd_ff;
   logic [7:0] param_ff;
   logic [7:0] chan_ff [3];
   logic       fe_ff;

   // Divider lanes: remainder and dividend/quotient shift register.
   logic [7:0]  rem_ff [3];
   logic [15:0] nq_ff  [3];

   logic [4:0] cnt_eff;
   logic [7:0] max_eff;
   logic [4:0] sel_inc;
   logic [7:0] quo_sat [3];

   lpdc_pkg::rsp_type rsp_ff, rsp_in;

   assign dp_status.is_pixel = is_pixel_ff;
   assign dp_status.running  = running_ff;
   assign rsp_out            = rsp_ff;

   assign cnt_eff = (pattern_count_ff == 5'd0) ? 5'd1 :
                    ((pattern_count_ff > LIMIT) ? LIMIT : pattern_count_ff);
   assign max_eff = (brightness_max_ff == 8'd0) ? 8'd1 : brightness_max_ff;
   assign sel_inc = {1'b0, sel_ff} + 5'd1;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         quo_sat[i] = (|nq_ff[i][15:8]) ? 8'hFF : nq_ff[i][7:0];
      end
   end

   always_comb begin
      running_in = running_ff;
      level_in   = level_ff;
      sel_in     = sel_ff;
      rsp_in     = '0;
      if (!is_pixel_ff) begin
         case (cmd_ff)
            lpdc_pkg::CMD_TOGGLE: begin
               running_in         = !running_ff;
               rsp_in.start_pulse = !running_ff;
               rsp_in.stop_pulse  = running_ff;
            end
            lpdc_pkg::CMD_NEXT: begin
               sel_in = (sel_inc >= cnt_eff) ? 4'd0 : sel_inc[3:0];
            end
            lpdc_pkg::CMD_PREVIOUS: begin
               if (sel_ff == 4'd0 || {1'b0, sel_ff} >= cnt_eff) begin
                  sel_in = 4'(cnt_eff - 5'd1);
               end else begin
                  sel_in = sel_ff - 4'd1;
               end
            end
            lpdc_pkg::CMD_SELECT: begin
               if (param_ff >= {3'd0, cnt_eff}) begin
                  rsp_in.status = 1'b1;
               end else begin
                  sel_in = param_ff[3:0];
               end
            end
            lpdc_pkg::CMD_DIM: begin
               if (level_ff != 8'd0) begin
                  level_in          = level_ff - 8'd1;
                  rsp_in.stop_pulse = (level_ff == 8'd1);
               end
            end
            lpdc_pkg::CMD_BRIGHTEN: begin
               if (level_ff < max_eff) begin
                  level_in           = level_ff + 8'd1;
                  rsp_in.start_pulse = (level_ff == 8'd0);
               end
            end
            default: begin
            end
         endcase
      end else begin
         rsp_in.frame_end_out = fe_ff;
         if (running_ff) begin
            rsp_in.pixel_drawn = 1'b1;
            rsp_in.out_red     = quo_sat[0];
            rsp_in.out_green   = quo_sat[1];
            rsp_in.out_blue    = quo_sat[2];
         end else begin
            rsp_in.out_red     = chan_ff[0];
            rsp_in.out_green   = chan_ff[1];
            rsp_in.out_blue    = chan_ff[2];
         end
      end
      rsp_in.pattern_index = sel_in;
      rsp_in.is_on         = running_in;
      rsp_in.level         = level_in;
   end

   // Control and configuration state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_count_ff  <= lpdc_pkg::PATTERN_COUNT_RESET;
         brightness_max_ff <= lpdc_pkg::BRIGHTNESS_MAX_RESET;
         running_ff        <= 1'b1;
         level_ff          <= lpdc_pkg::BRIGHTNESS_MAX_RESET;
         sel_ff            <= 4'd0;
      end else begin
         if (csr_valid && csr_index == lpdc_pkg::CSR_PATTERN_COUNT) begin
            pattern_count_ff <= csr_data[4:0];
         end
         if (csr_valid && csr_index == lpdc_pkg::CSR_BRIGHTNESS_MAX) begin
            brightness_max_ff <= csr_data[7:0];
         end
         if (ctrl_cmd.out_load) begin
            running_ff <= running_in;
            level_ff   <= level_in;
            sel_ff     <= sel_in;
         end
      end
   end

   // Payload: input latch, multiply, divide steps and result register.
   always_ff @(posedge clock) begin
      if (ctrl_cmd.load_input) begin
         is_pixel_ff <= in_req_type;
         cmd_ff      <= in_command;
         param_ff    <= in_param;
         chan_ff[0]  <= in_red;
         chan_ff[1]  <= in_green;
         chan_ff[2]  <= in_blue;
         fe_ff       <= in_frame_end;
      end
      for (int i = 0; i < 3; i++) begin
         if (ctrl_cmd.mult) begin
            nq_ff[i]  <= 16'(chan_ff[i] * level_ff);
            rem_ff[i] <= 8'd0;
         end else if (ctrl_cmd.div_step) begin
            if ({rem_ff[i], nq_ff[i][15]} >= {1'b0, max_eff}) begin
               rem_ff[i] <= 8'({rem_ff[i], nq_ff[i][15]} - {1'b0, max_eff});
               nq_ff[i]  <= {nq_ff[i][14:0], 1'b1};
            end else begin
               rem_ff[i] <= {rem_ff[i][6:0], nq_ff[i][15]};
               nq_ff[i]  <= {nq_ff[i][14:0], 1'b0};
            end
         end
      end
      if (ctrl_cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

### rtl/led_pattern_dimmer_control_top.sv
// ----------------------------------------------------------------------------
// led_pattern_dimmer_control_top
// LED pattern controller with brightness dimming and per-pixel scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Each request beat is either a command (tuser low) or one rendered pixel
// (tuser high), and every request beat produces exactly one response beat.
// Commands toggle the controller, step or select the pattern and move the
// brightness level by one; a pixel is scaled per channel to
// floor(c * level / max) while the controller is on and passes unchanged
// otherwise. The block handles one beat at a time. A command, or a pixel
// while the controller is off, passes through the multiply state and then
// the finish state, which loads the result. A pixel while the controller is
// on also runs, between the two, a bit-per-cycle restoring divider that
// works on the three color channels side by side.
// A finished response waits in an output register, so a new request beat is
// taken while the previous response is still waiting; the block only
// pauses when a second response is ready before the first has been taken.
// Configuration writes are always accepted and must be issued while the
// block is idle.
module led_pattern_dimmer_control_top (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // From bit 0: command[2:0], param[10:3], red[18:11], green[26:19],
   // blue[34:27], zero fill[39:35].
   input  wire logic [lpdc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // Bit 0: req_type (0 command, 1 pixel).
   input  wire logic                                req_tuser,
   // Frame end marker of a pixel beat.
   input  wire logic                                req_tlast,

   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // From bit 0: status[0], start_pulse[1], stop_pulse[2],
   // pattern_index[6:3], is_on[7], level[15:8], out_red[23:16],
   // out_green[31:24], out_blue[39:32].
   output      logic [lpdc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // Bit 0: pixel_drawn.
   output      logic                                rsp_tuser,
   // frame_end_out.
   output      logic                                rsp_tlast,

   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [lpdc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [lpdc_pkg::CSR_DATA_W-1:0]     csr_data
);

   lpdc_pkg::ctrl_cmd_type  ctrl_cmd;
   lpdc_pkg::dp_status_type dp_status;
   lpdc_pkg::rsp_type       rsp;

   // Register writes go straight into the configuration registers, so the port never stalls.
   assign csr_ready = 1'b1;

   lpdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   lpdc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .in_req_type  (req_tuser),
      .in_command   (req_tdata[2:0]),
      .in_param     (req_tdata[10:3]),
      .in_red       (req_tdata[18:11]),
      .in_green     (req_tdata[26:19]),
      .in_blue      (req_tdata[34:27]),
      .in_frame_end (req_tlast),
      .ctrl_cmd     (ctrl_cmd),
      .dp_status    (dp_status),
      .rsp_out      (rsp)
   );

   // Pack the response fields onto the stream, lowest field first.
   assign rsp_tdata = {rsp.out_blue, rsp.out_green, rsp.out_red, rsp.level, rsp.is_on,
                       rsp.pattern_index, rsp.stop_pulse, rsp.start_pulse, rsp.status};
   assign rsp_tuser = rsp.pixel_drawn;
   assign rsp_tlast = rsp.frame_end_out;

endmodule

`default_nettype wire
